@@ rtl/core/trot_pkg.sv @@
// Shared types and helpers for the triangle/rectangle overlap core.
// Holds the sign pair type, sign arithmetic and configuration register codes.
package trot_pkg;

    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_VA_X = 3'd0,
        CFG_VA_Y = 3'd1,
        CFG_VB_X = 3'd2,
        CFG_VB_Y = 3'd3,
        CFG_VC_X = 3'd4,
        CFG_VC_Y = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic pos;
        logic neg;
    } sgn_t;

    function automatic sgn_t sgn_neg(input sgn_t a);
        sgn_t r;
        r.pos = a.neg;
        r.neg = a.pos;
        return r;
    endfunction

    function automatic sgn_t sgn_mul(input sgn_t a, input sgn_t b);
        sgn_t r;
        r.pos = (a.pos & b.pos) | (a.neg & b.neg);
        r.neg = (a.pos & b.neg) | (a.neg & b.pos);
        return r;
    endfunction

    function automatic logic sgn_opposite(input sgn_t a, input sgn_t b);
        return (a.pos & b.neg) | (a.neg & b.pos);
    endfunction

endpackage

@@ rtl/core/triangle_rect_overlap_test_core.sv @@
// Triangle versus axis-aligned rectangle overlap test, four-stage pipeline.
// Depends on trot_pkg for sign types, sign helpers and register codes.
//
// Usage:
//   The triangle is loaded through the cfg channel (cfg_index 0..5 selects
//   vertex A x/y, B x/y, C x/y; other indexes are ignored). cfg_ready is
//   always high. Load it only while no word is in flight.
//   Each word on the s_ channel is one rectangle (left, bottom, right, top);
//   the m_ channel returns one word per rectangle, m_overlaps = 1 on overlap.
//   One word is taken per cycle while m_ready does not stall the output;
//   the stages are edge/offset subtraction, the edge-by-offset multiplies
//   for every edge and corner, the cross product compares, and the final vote.
//   A stall on m_ready freezes every stage in place; s_ready drops only
//   while a result waits and m_ready is low, so no word is lost or repeated.
//   Reset clears the triangle to all-zero vertices and empties the pipeline.
module triangle_rect_overlap_test_core #(
    parameter int COORD_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [trot_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [COORD_BITS-1:0]                cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_BITS-1:0]         s_rect_left,
    input  logic signed [COORD_BITS-1:0]         s_rect_bottom,
    input  logic signed [COORD_BITS-1:0]         s_rect_right,
    input  logic signed [COORD_BITS-1:0]         s_rect_top,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_overlaps
);
    import trot_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [COORD_BITS-1:0] vx_reg [3];
    logic signed [COORD_BITS-1:0] vy_reg [3];

    logic adv;
    logic v1_reg, v2_reg, v3_reg, m_valid_reg, m_overlaps_reg;

    // stage 1
    logic signed [DW-1:0] ex_next [3], ey_next [3];
    logic signed [DW-1:0] dxl_next [3], dxr_next [3], dyb_next [3], dyt_next [3];
    logic signed [DW-1:0] ex_reg [3], ey_reg [3];
    logic signed [DW-1:0] dxl_reg [3], dxr_reg [3], dyb_reg [3], dyt_reg [3];
    sgn_t rsg_next [4][3];
    sgn_t rsg1_reg [4][3];
    logic vhit_next, vhit1_reg;

    // stage 2
    logic signed [PW-1:0] m1_next [3][4], m2_next [3][4];
    logic signed [PW-1:0] m1_reg [3][4], m2_reg [3][4];
    sgn_t rsg2_reg [4][3];
    logic vhit2_reg;

    // stage 3
    sgn_t esg_next [3][4];
    sgn_t esg_reg [3][4];
    sgn_t rsg3_reg [4][3];
    logic vhit3_reg;

    // stage 4
    logic overlaps_next;

    assign cfg_ready  = 1'b1;
    assign adv        = !m_valid_reg || m_ready;
    assign s_ready    = adv;
    assign m_valid    = m_valid_reg;
    assign m_overlaps = m_overlaps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_VA_X: vx_reg[0] <= cfg_data;
                CFG_VA_Y: vy_reg[0] <= cfg_data;
                CFG_VB_X: vx_reg[1] <= cfg_data;
                CFG_VB_Y: vy_reg[1] <= cfg_data;
                CFG_VC_X: vx_reg[2] <= cfg_data;
                CFG_VC_Y: vy_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic signed [DW-1:0] rl, rb, rr, rt, w_rl, w_tb;
        sgn_t s_rl, s_tb, s_dxl, s_dxr, s_dyb, s_dyt;
        rl = DW'(s_rect_left);
        rb = DW'(s_rect_bottom);
        rr = DW'(s_rect_right);
        rt = DW'(s_rect_top);
        w_rl = rr - rl;
        w_tb = rt - rb;
        s_rl.pos = !w_rl[DW-1] && (w_rl != '0);
        s_rl.neg = w_rl[DW-1];
        s_tb.pos = !w_tb[DW-1] && (w_tb != '0);
        s_tb.neg = w_tb[DW-1];
        vhit_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            ex_next[i]  = DW'(vx_reg[(i + 1) % 3]) - DW'(vx_reg[i]);
            ey_next[i]  = DW'(vy_reg[(i + 1) % 3]) - DW'(vy_reg[i]);
            dxl_next[i] = rl - DW'(vx_reg[i]);
            dxr_next[i] = rr - DW'(vx_reg[i]);
            dyb_next[i] = rb - DW'(vy_reg[i]);
            dyt_next[i] = rt - DW'(vy_reg[i]);
            s_dxl.pos = !dxl_next[i][DW-1] && (dxl_next[i] != '0);
            s_dxl.neg = dxl_next[i][DW-1];
            s_dxr.pos = !dxr_next[i][DW-1] && (dxr_next[i] != '0);
            s_dxr.neg = dxr_next[i][DW-1];
            s_dyb.pos = !dyb_next[i][DW-1] && (dyb_next[i] != '0);
            s_dyb.neg = dyb_next[i][DW-1];
            s_dyt.pos = !dyt_next[i][DW-1] && (dyt_next[i] != '0);
            s_dyt.neg = dyt_next[i][DW-1];
            if (!s_dxl.pos && !s_dxr.neg && !s_dyb.pos && !s_dyt.neg) begin
                vhit_next = 1'b1;
            end
            rsg_next[0][i] = sgn_mul(s_rl, sgn_neg(s_dyb));
            rsg_next[1][i] = sgn_mul(s_tb, s_dxr);
            rsg_next[2][i] = sgn_mul(s_rl, s_dyt);
            rsg_next[3][i] = sgn_mul(s_tb, sgn_neg(s_dxl));
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 4; j++) begin
                m1_next[i][j] = ex_reg[i] * ((j >= 2) ? dyt_reg[i] : dyb_reg[i]);
                m2_next[i][j] = ey_reg[i] *
                                ((j == 1 || j == 2) ? dxr_reg[i] : dxl_reg[i]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 4; j++) begin
                esg_next[i][j].pos = m1_reg[i][j] > m2_reg[i][j];
                esg_next[i][j].neg = m1_reg[i][j] < m2_reg[i][j];
            end
        end
    end

    always_comb begin
        logic any_pos, any_neg;
        overlaps_next = vhit3_reg;
        for (int j = 0; j < 4; j++) begin
            any_pos = esg_reg[0][j].pos | esg_reg[1][j].pos | esg_reg[2][j].pos;
            any_neg = esg_reg[0][j].neg | esg_reg[1][j].neg | esg_reg[2][j].neg;
            if (!(any_pos && any_neg)) begin
                overlaps_next = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 4; j++) begin
                if (sgn_opposite(esg_reg[i][j], esg_reg[i][(j + 1) % 4]) &&
                    sgn_opposite(rsg3_reg[j][i], rsg3_reg[j][(i + 1) % 3])) begin
                    overlaps_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ex_reg    <= ex_next;
            ey_reg    <= ey_next;
            dxl_reg   <= dxl_next;
            dxr_reg   <= dxr_next;
            dyb_reg   <= dyb_next;
            dyt_reg   <= dyt_next;
            rsg1_reg  <= rsg_next;
            vhit1_reg <= vhit_next;

            m1_reg    <= m1_next;
            m2_reg    <= m2_next;
            rsg2_reg  <= rsg1_reg;
            vhit2_reg <= vhit1_reg;

            esg_reg   <= esg_next;
            rsg3_reg  <= rsg2_reg;
            vhit3_reg <= vhit2_reg;

            m_overlaps_reg <= overlaps_next;
        end
    end

    a_vertex_hit_forces_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && v3_reg && vhit3_reg) |=> (m_valid_reg && m_overlaps_reg))
        else $error("vertex inside rectangle did not yield overlap");

    a_bubble_stays_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !v3_reg) |=> !m_valid_reg)
        else $error("result produced from empty stage");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input held off with empty output");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(v3_reg) && $stable(vhit3_reg)))
        else $error("pipeline moved during stall");

endmodule
